### rtl/epsm_pkg.sv
// Shared types, command codes and sizing constants of the pattern stream matcher.
`timescale 1ns / 1ps
`default_nettype none

package epsm_pkg;

    localparam int DefaultMaxPattern = 32;
    localparam int DefaultMaxText    = 65535;
    localparam int StartW            = 17;

    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_PATTERN = 2'd1;
    localparam logic [1:0] CMD_TEXT    = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] ch;
    } item_t;

    typedef struct packed {
        logic              matched;
        logic [StartW-1:0] start_index;
        logic              ignored;
    } result_t;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic       clr;
        logic       load;
        logic       step;
        logic [7:0] ch;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/epsm_cell.sv
// One cell of the matching chain: a pattern byte and its partial-match bit.
`timescale 1ns / 1ps
`default_nettype none

module epsm_cell
    import epsm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       load_sel,
    input  wire logic       active,
    input  wire logic       prev_part,
    output logic            part,
    output logic            part_upd
);

    logic [7:0] char_reg;
    logic       part_reg;
    logic       part_next;

    // The pattern byte has no reset; its compare only counts once it has been written.
    always_ff @(posedge clk)
    begin
        if (ctrl.load && load_sel)
        begin
            char_reg <= ctrl.ch;
        end
    end

    assign part_upd = prev_part && (char_reg == ctrl.ch);

    always_comb
    begin
        part_next = part_reg;
        if (ctrl.clr)
        begin
            part_next = 1'b0;
        end
        else if (ctrl.step && active)
        begin
            part_next = part_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg <= 1'b0;
        end
        else
        begin
            part_reg <= part_next;
        end
    end

    assign part = part_reg;

endmodule

`default_nettype wire

### rtl/exact_pattern_stream_matcher.sv
// Top level of the exact pattern stream matcher: command decode, cell chain and result register.
`timescale 1ns / 1ps
`default_nettype none

// One beat in gives one result beat out on the next cycle, and a new beat can be taken
// in every cycle while the result side keeps up; the registered result stage lets the input
// take the next beat in the same cycle that the waiting result is taken. A start beat clears
// the job, pattern beats load the cells one after another (up to MAX_PATTERN bytes), and each
// text beat is compared against every pattern byte at once: each cell checks its byte and
// takes the partial-match bit of its left neighbour, so a full match at the last loaded cell
// is known in the same cycle. The start index reported is pattern length plus one plus the
// 1-based text position of the first matched byte, kept to 17 bits. Rejected beats (pattern
// full, pattern after text, text beyond MAX_TEXT, unused command) change nothing and are
// flagged as ignored.
module exact_pattern_stream_matcher
    import epsm_pkg::*;
#(
    parameter int MAX_PATTERN = DefaultMaxPattern,
    parameter int MAX_TEXT    = DefaultMaxText
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);

    localparam int LenW = $clog2(MAX_PATTERN + 1);
    localparam int PosW = $clog2(MAX_TEXT + 1);
    localparam int SumW = ((PosW > StartW) ? PosW : StartW) + 1;

    logic [LenW-1:0]        len_reg;
    logic [LenW-1:0]        len_next;
    logic [PosW-1:0]        pos_reg;
    logic [PosW-1:0]        pos_next;
    logic                   text_started_reg;
    logic                   text_started_next;
    logic                   result_valid_reg;
    logic                   result_valid_next;
    result_t                result_reg;
    result_t                result_next;

    logic                   accept;
    logic                   pat_ok;
    logic                   text_ok;
    logic                   ignored;
    logic                   hit;
    logic [SumW-1:0]        start_sum;
    cell_ctrl_t             ctrl;

    logic [MAX_PATTERN-1:0] part_vec;
    logic [MAX_PATTERN-1:0] upd_vec;
    logic [MAX_PATTERN-1:0] active_vec;
    logic [MAX_PATTERN-1:0] last_vec;

    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    assign pat_ok  = !text_started_reg && (len_reg < LenW'(MAX_PATTERN));
    assign text_ok = pos_reg < PosW'(MAX_TEXT);

    always_comb
    begin
        ctrl.clr  = 1'b0;
        ctrl.load = 1'b0;
        ctrl.step = 1'b0;
        ctrl.ch   = item.ch;
        ignored   = 1'b0;
        case (item.cmd)
            CMD_START:
            begin
                ctrl.clr = accept;
            end
            CMD_PATTERN:
            begin
                ctrl.load = accept && pat_ok;
                ignored   = !pat_ok;
            end
            CMD_TEXT:
            begin
                ctrl.step = accept && text_ok;
                ignored   = !text_ok;
            end
            default:
            begin
                ignored = 1'b1;
            end
        endcase
    end

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            logic prev_part;

            if (k == 0)
            begin : g_head
                assign prev_part = 1'b1;
            end
            else
            begin : g_link
                assign prev_part = part_vec[k-1];
            end

            assign active_vec[k] = len_reg > LenW'(k);
            assign last_vec[k]   = len_reg == LenW'(k + 1);

            epsm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .load_sel  (len_reg == LenW'(k)),
                .active    (active_vec[k]),
                .prev_part (prev_part),
                .part      (part_vec[k]),
                .part_upd  (upd_vec[k])
            );
        end
    endgenerate

    // Only the cell holding the last pattern byte can report a full match.
    assign hit = |(last_vec & upd_vec);

    // The first matched position is pos_reg + 2 - len, so the index collapses to pos_reg + 3.
    assign start_sum = SumW'(pos_reg) + SumW'(3);

    always_comb
    begin
        len_next          = len_reg;
        pos_next          = pos_reg;
        text_started_next = text_started_reg;
        if (ctrl.clr)
        begin
            len_next          = '0;
            pos_next          = '0;
            text_started_next = 1'b0;
        end
        else if (ctrl.load)
        begin
            len_next = len_reg + LenW'(1);
        end
        else if (ctrl.step)
        begin
            pos_next          = pos_reg + PosW'(1);
            text_started_next = 1'b1;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if (accept)
        begin
            result_valid_next       = 1'b1;
            result_next.matched     = ctrl.step && hit;
            result_next.start_index = (ctrl.step && hit) ? start_sum[StartW-1:0] : '0;
            result_next.ignored     = ignored;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg          <= '0;
            pos_reg          <= '0;
            text_started_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg          <= len_next;
            pos_reg          <= pos_next;
            text_started_reg <= text_started_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // Cells past the loaded pattern never hold a partial match.
    a_idle_cells_clear : assert property (@(posedge clk) disable iff (!rst_n)
        (part_vec & ~active_vec) == '0)
        else $error("partial match bit set beyond pattern length");

    a_len_bound : assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LenW'(MAX_PATTERN))
        else $error("pattern length beyond bound");

    a_start_clears : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.cmd == CMD_START) |=>
            (len_reg == '0 && pos_reg == '0 && !text_started_reg))
        else $error("start beat did not clear the job");

    a_match_not_ignored : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(result_reg.matched && result_reg.ignored))
        else $error("result both matched and ignored");
`endif

endmodule

`default_nettype wire
